/* design/swla_pkg.sv */
// Package for the sliding-window layer assigner: sizes, transaction structs,
// controller/datapath command and status groups, and register indexes.
// No dependencies.
`default_nettype none

package swla_pkg;

   localparam int NUM_SLOTS     = 8192;
   localparam int SLOT_BITS     = 13;
   localparam int MAX_LAYERS    = 64;
   localparam int LAYER_BITS    = 6;
   localparam int COUNT_BITS    = 7;
   localparam int BLOCK_BITS    = 10;
   localparam int SPAN_BITS     = 11;
   localparam int BUDGET_BITS   = 7;
   localparam int EPOCH_BITS    = 8;
   localparam int CSR_DATA_BITS = 11;
   localparam int CSR_IDX_BITS  = 1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WINDOW_SPAN  = 1'b0,
      CSR_LAYER_BUDGET = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                  start_new_set;
      logic [SLOT_BITS-1:0]  bin;
      logic [BLOCK_BITS-1:0] block;
   } req_type;

   typedef struct packed {
      logic [LAYER_BITS-1:0] layer_index;
      logic                  opened_new;
      logic [COUNT_BITS-1:0] layers_used;
      logic                  over_budget;
   } rsp_type;

   typedef struct packed {
      logic [EPOCH_BITS-1:0] tag;
      logic [MAX_LAYERS-1:0] bits;
   } occ_entry_type;

   typedef struct packed {
      logic load;        // latch the accepted transaction
      logic clear_wr;    // write one zero entry of the clearing pass
      logic retire_rd;   // read the first block of the oldest active layer
      logic retire_adv;  // retire the oldest active layer
      logic occ_rd;      // read the occupancy entry of the item's bin
      logic place;       // place the item and load the result register
   } dp_cmd_type;

   typedef struct packed {
      logic retire_pending;  // an active layer is left to test
      logic retire_hit;      // the tested layer's window has closed
      logic epoch_last;      // the next new set wraps the epoch
      logic clear_last;      // the clearing pass is at its final entry
   } dp_status_type;

endpackage

`default_nettype wire

/* design/swla_ctrl.sv */
// Controller state machine of the sliding-window layer assigner.
// Drives the datapath commands and both handshakes; uses swla_pkg.
`default_nettype none

module swla_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    req_start_new_set,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output swla_pkg::dp_cmd_type    cmd,
   input  wire swla_pkg::dp_status_type status
);
   import swla_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RETIRE_RD,
      ST_RETIRE_CHK,
      ST_PLACE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      pending_ff, pending_in;
   logic      accept;
   logic      rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in   = pending_ff ? ST_RETIRE_RD : ST_IDLE;
               pending_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               // A new set that wraps the epoch needs the store wiped first.
               if (req_start_new_set && status.epoch_last) begin
                  state_in   = ST_CLEAR;
                  pending_in = 1'b1;
               end else begin
                  state_in = ST_RETIRE_RD;
               end
            end
         end
         ST_RETIRE_RD: begin
            if (status.retire_pending) begin
               cmd.retire_rd = 1'b1;
               state_in      = ST_RETIRE_CHK;
            end else begin
               cmd.occ_rd = 1'b1;
               state_in   = ST_PLACE;
            end
         end
         ST_RETIRE_CHK: begin
            if (status.retire_hit) begin
               cmd.retire_adv = 1'b1;
               state_in       = ST_RETIRE_RD;
            end else begin
               cmd.occ_rd = 1'b1;
               state_in   = ST_PLACE;
            end
         end
         ST_PLACE: begin
            if (rsp_free) begin
               cmd.place    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pending_ff   <= pending_in;
      end
   end

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

   a_place_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.place |=> rsp_valid_ff)
      else $error("placement did not present a result");

   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> req_stall)
      else $error("input taken during the clearing pass");

endmodule

`default_nettype wire

/* design/swla_dp.sv */
// Datapath of the sliding-window layer assigner: occupancy store with epoch
// tags, first-block store, counters, configuration and result registers.
// Uses swla_pkg; commanded by swla_ctrl.
`default_nettype none

module swla_dp (
   input  wire                          clock,
   input  wire                          reset,
   input  wire swla_pkg::req_type        req_data,
   output swla_pkg::rsp_type             rsp_data,
   input  wire                          csr_write_enable,
   input  wire [swla_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire [swla_pkg::CSR_DATA_BITS-1:0] csr_write_data,
   input  wire swla_pkg::dp_cmd_type     cmd,
   output swla_pkg::dp_status_type       status
);
   import swla_pkg::*;

   occ_entry_type           occ_mem [NUM_SLOTS];
   logic [BLOCK_BITS-1:0]   first_mem [MAX_LAYERS];

   req_type                 item_ff;
   rsp_type                 rsp_ff;
   occ_entry_type           occ_rd_ff;
   logic [BLOCK_BITS-1:0]   first_rd_ff;
   logic [COUNT_BITS-1:0]   count_ff, oldest_ff;
   logic [EPOCH_BITS-1:0]   epoch_ff;
   logic [SLOT_BITS-1:0]    clear_cnt_ff;
   logic [SPAN_BITS-1:0]    span_ff;
   logic [BUDGET_BITS-1:0]  budget_ff;

   logic [MAX_LAYERS-1:0]   word, in_range, free_bits, lowest, chosen_bit;
   logic [LAYER_BITS-1:0]   free_idx, chosen;
   logic [BUDGET_BITS-1:0]  budget_eff;
   logic                    found, can_open, place_opened, place_over;
   logic [SPAN_BITS:0]      window_end;
   logic                    occ_we;
   logic [SLOT_BITS-1:0]    occ_wa;
   occ_entry_type           occ_wd;

   // Entries tagged with an older epoch belong to a finished set and read as empty.
   assign word = (occ_rd_ff.tag == epoch_ff) ? occ_rd_ff.bits : '0;

   always_comb begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
         in_range[i] = (COUNT_BITS'(i) >= oldest_ff) && (COUNT_BITS'(i) < count_ff);
      end
   end

   assign free_bits = ~word & in_range;
   assign found     = |free_bits;
   assign lowest    = free_bits & (~free_bits + MAX_LAYERS'(1));

   always_comb begin
      free_idx = '0;
      for (int k = 0; k < LAYER_BITS; k++) begin
         for (int i = 0; i < MAX_LAYERS; i++) begin
            if (((i >> k) & 1) == 1) begin
               free_idx[k] = free_idx[k] | lowest[i];
            end
         end
      end
   end

   assign budget_eff   = (budget_ff > BUDGET_BITS'(MAX_LAYERS)) ?
                         BUDGET_BITS'(MAX_LAYERS) : budget_ff;
   assign can_open     = (count_ff < budget_eff);
   assign place_opened = !found && can_open;
   assign place_over   = !found && !can_open;
   assign chosen       = found ? free_idx : count_ff[LAYER_BITS-1:0];

   always_comb begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
         chosen_bit[i] = (chosen == LAYER_BITS'(i));
      end
   end

   assign window_end = {1'b0, first_rd_ff} + {1'b0, span_ff};

   assign status.retire_pending = (oldest_ff < count_ff);
   assign status.retire_hit     = (window_end <= (SPAN_BITS + 1)'(item_ff.block));
   assign status.epoch_last     = (epoch_ff == '1);
   assign status.clear_last     = (clear_cnt_ff == SLOT_BITS'(NUM_SLOTS - 1));

   assign occ_we = cmd.clear_wr || (cmd.place && !place_over);
   assign occ_wa = cmd.clear_wr ? clear_cnt_ff : item_ff.bin;
   always_comb begin
      occ_wd.tag  = epoch_ff;
      occ_wd.bits = cmd.clear_wr ? '0 : (word | chosen_bit);
   end

   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[occ_wa] <= occ_wd;
      end
      if (cmd.occ_rd) begin
         occ_rd_ff <= occ_mem[item_ff.bin];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.place && place_opened) begin
         first_mem[chosen] <= item_ff.block;
      end
      if (cmd.retire_rd) begin
         first_rd_ff <= first_mem[oldest_ff[LAYER_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.place) begin
         rsp_ff.layer_index <= place_over ? '0 : chosen;
         rsp_ff.opened_new  <= place_opened;
         rsp_ff.layers_used <= place_opened ? count_ff + COUNT_BITS'(1) : count_ff;
         rsp_ff.over_budget <= place_over;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         oldest_ff    <= '0;
         epoch_ff     <= '0;
         clear_cnt_ff <= '0;
         span_ff      <= SPAN_BITS'(1);
         budget_ff    <= BUDGET_BITS'(MAX_LAYERS);
      end else begin
         if (cmd.load && req_data.start_new_set) begin
            count_ff  <= '0;
            oldest_ff <= '0;
            epoch_ff  <= epoch_ff + EPOCH_BITS'(1);
         end
         if (cmd.retire_adv) begin
            oldest_ff <= oldest_ff + COUNT_BITS'(1);
         end
         if (cmd.place && place_opened) begin
            count_ff <= count_ff + COUNT_BITS'(1);
         end
         if (cmd.clear_wr) begin
            clear_cnt_ff <= clear_cnt_ff + SLOT_BITS'(1);
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_WINDOW_SPAN:  span_ff   <= csr_write_data[SPAN_BITS-1:0];
               CSR_LAYER_BUDGET: budget_ff <= csr_write_data[BUDGET_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_data = rsp_ff;

   a_oldest_le_count: assert property (@(posedge clock) disable iff (reset)
      oldest_ff <= count_ff)
      else $error("oldest active layer beyond the layer count");

   a_open_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.place && place_opened) |=> (count_ff == $past(count_ff) + COUNT_BITS'(1)))
      else $error("opening a layer did not advance the count");

   a_chosen_active: assert property (@(posedge clock) disable iff (reset)
      (cmd.place && found) |-> ((COUNT_BITS'(chosen) >= oldest_ff) &&
                                (COUNT_BITS'(chosen) < count_ff)))
      else $error("item placed in a layer outside the active window");

endmodule

`default_nettype wire

/* design/sliding_window_layer_assigner_unit.sv */
// Channel  Direction  Ports                          Payload
// req      in         req_valid, req_stall, req_data  swla_pkg::req_type
// rsp      out        rsp_valid, rsp_stall, rsp_data  swla_pkg::rsp_type
// csr      in         csr_write_enable, csr_index,    window span, layer budget
//                     csr_write_data
//
// An item is placed once the retirement loop has retired every layer whose window has closed;
// the retirement loop reads the first-block store once per layer and the occupancy store
// has one port.
// After reset, and on every 256th new set when the epoch tag wraps, a clearing
// pass zeroes all 8192 entries of the occupancy store while req_stall stays high.
// Reset is synchronous; a finished result waits in the output register while the
// next transaction is accepted, and only placement waits on rsp_stall.
//
// Top level of the sliding-window layer assigner; instantiates swla_ctrl and swla_dp.
`default_nettype none

module sliding_window_layer_assigner_unit (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire swla_pkg::req_type             req_data,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output swla_pkg::rsp_type                  rsp_data,
   input  wire                               csr_write_enable,
   input  wire [swla_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire [swla_pkg::CSR_DATA_BITS-1:0] csr_write_data
);
   import swla_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   swla_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_start_new_set (req_data.start_new_set),
      .req_stall         (req_stall),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .cmd               (cmd),
      .status            (status)
   );

   swla_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

/* tb/sv/tb_sliding_window_layer_assigner_unit.sv */
// Self-checking testbench for sliding_window_layer_assigner_unit: a table of directed
// transactions, then random phases under several register settings, checked against
// a layer-assignment predictor or fixed table results. Depends on swla_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_sliding_window_layer_assigner_unit;
   import swla_pkg::*;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type index;
      int unsigned   value;
      req_type       item;
      bit            fixed;
      rsp_type       result;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;

   // Predictor state, kept apart from the block.
   bit [MAX_LAYERS-1:0] occ_map [NUM_SLOTS];
   bit [BLOCK_BITS-1:0] first_blk [MAX_LAYERS];
   int unsigned         layer_total = 0;
   int unsigned         oldest_layer = 0;
   int unsigned         span_reg = 1;
   int unsigned         budget_reg = 64;

   rsp_type expected_placements [$];
   int      error_count = 0;
   int      burst_left = 0;
   int      stall_run = 0;
   int      stall_mode = 0;

   sliding_window_layer_assigner_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #6_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic rsp_type predict_placement(input req_type item);
      rsp_type     res;
      int unsigned blk;
      int unsigned slot;
      int unsigned limit;
      bit          placed;
      blk    = 32'(item.block);
      slot   = 32'(item.bin);
      limit  = (budget_reg > MAX_LAYERS) ? MAX_LAYERS : budget_reg;
      placed = 1'b0;
      res    = '0;
      if (item.start_new_set) begin
         foreach (occ_map[s]) occ_map[s] = '0;
         layer_total  = 0;
         oldest_layer = 0;
      end
      // Layers whose window has closed retire oldest first.
      while (oldest_layer < layer_total && first_blk[oldest_layer] + span_reg <= blk)
         oldest_layer++;
      for (int unsigned li = oldest_layer; li < layer_total && !placed; li++) begin
         if (!occ_map[slot][li]) begin
            occ_map[slot][li] = 1'b1;
            res.layer_index   = LAYER_BITS'(li);
            placed            = 1'b1;
         end
      end
      if (!placed) begin
         if (layer_total < limit) begin
            occ_map[slot][layer_total] = 1'b1;
            first_blk[layer_total]     = BLOCK_BITS'(blk);
            res.layer_index            = LAYER_BITS'(layer_total);
            res.opened_new             = 1'b1;
            layer_total++;
         end else begin
            res.over_budget = 1'b1;
         end
      end
      res.layers_used = COUNT_BITS'(layer_total);
      return res;
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Presents one transaction, honouring the burst pattern, and returns at the
   // edge at which it is accepted.
   task automatic send_request(input req_type item, input bit fixed, input rsp_type fixed_rsp);
      int      gap;
      rsp_type predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_placement(item);
      if (fixed) predicted = fixed_rsp;
      expected_placements.insert(expected_placements.size(), predicted);
   endtask

   // Registers change only once the block has drained every transaction.
   task automatic write_register(input csr_index_type index, input int unsigned value);
      req_valid <= 1'b0;
      while (expected_placements.size() != 0 || req_stall) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_WINDOW_SPAN) span_reg = value & 32'h7FF;
      else budget_reg = value & 32'h7F;
      @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned span, input int unsigned budget,
                            input int count, input int start_pct);
      logic [SLOT_BITS-1:0]  bin_pool [6];
      logic [BLOCK_BITS-1:0] cur_block;
      req_type               item;
      int                    roll;
      write_register(CSR_WINDOW_SPAN, span);
      write_register(CSR_LAYER_BUDGET, budget);
      foreach (bin_pool[i]) bin_pool[i] = SLOT_BITS'($urandom_range(0, NUM_SLOTS - 1));
      if ($urandom_range(0, 1)) bin_pool[0] = '0;
      if ($urandom_range(0, 1)) bin_pool[1] = '1;
      cur_block = BLOCK_BITS'($urandom_range(0, 63));
      for (int n = 0; n < count; n++) begin
         item.start_new_set = (n == 0) || ($urandom_range(0, 99) < start_pct);
         roll = $urandom_range(0, 99);
         // Mostly slow block growth so that bins collide and layers pile up; the
         // odd long jump retires many layers at once, and a few steps go backwards.
         if (item.start_new_set) cur_block = BLOCK_BITS'($urandom);
         else if (roll < 60) cur_block = cur_block;
         else if (roll < 90) cur_block = BLOCK_BITS'(cur_block + $urandom_range(1, 2));
         else if (roll < 97) cur_block = BLOCK_BITS'(cur_block + $urandom_range(3, 64));
         else if (roll < 99) cur_block = BLOCK_BITS'(cur_block + $urandom_range(65, 1023));
         else cur_block = BLOCK_BITS'(cur_block - $urandom_range(1, 20));
         item.block = cur_block;
         item.bin = ($urandom_range(0, 99) < 85) ? bin_pool[$urandom_range(0, 5)]
                                                 : SLOT_BITS'($urandom);
         send_request(item, 1'b0, '0);
      end
   endtask

   stim_row_type directed_table [] = '{
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b1, 13'd0, 10'd0}, 1'b1, {6'd0, 1'b1, 7'd1, 1'b0}},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd0, 10'd0}, 1'b1, {6'd1, 1'b1, 7'd2, 1'b0}},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd8191, 10'd0}, 1'b1, {6'd0, 1'b0, 7'd2, 1'b0}},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd0, 10'd1}, 1'b0, '0},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd8191, 10'd1023}, 1'b0, '0},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd0, 10'd5}, 1'b0, '0},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd0, 10'd3}, 1'b0, '0},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b1, 13'd4660, 10'd1023}, 1'b1, {6'd0, 1'b1, 7'd1, 1'b0}},
      '{ROW_CSR, CSR_LAYER_BUDGET, 1, '0, 1'b0, '0},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b1, 13'd5, 10'd10}, 1'b1, {6'd0, 1'b1, 7'd1, 1'b0}},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd5, 10'd10}, 1'b1, {6'd0, 1'b0, 7'd1, 1'b1}},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd6, 10'd10}, 1'b0, '0},
      '{ROW_CSR, CSR_LAYER_BUDGET, 0, '0, 1'b0, '0},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b1, 13'd5, 10'd10}, 1'b1, {6'd0, 1'b0, 7'd0, 1'b1}},
      '{ROW_CSR, CSR_LAYER_BUDGET, 127, '0, 1'b0, '0},
      '{ROW_CSR, CSR_WINDOW_SPAN, 0, '0, 1'b0, '0},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b1, 13'd1, 10'd7}, 1'b1, {6'd0, 1'b1, 7'd1, 1'b0}},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd2, 10'd7}, 1'b0, '0},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd2, 10'd7}, 1'b0, '0},
      '{ROW_CSR, CSR_WINDOW_SPAN, 2047, '0, 1'b0, '0},
      '{ROW_CSR, CSR_LAYER_BUDGET, 64, '0, 1'b0, '0},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b1, 13'd3, 10'd0}, 1'b0, '0},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd3, 10'd512}, 1'b0, '0},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd3, 10'd1023}, 1'b0, '0},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd8191, 10'd1023}, 1'b0, '0},
      '{ROW_ITEM, CSR_WINDOW_SPAN, 0, {1'b0, 13'd3, 10'd1023}, 1'b0, '0}
   };

   // The receiver switches between free running, random stalls and long stalls.
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_run  = $urandom_range(1, 60);
      end
      stall_run--;
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 1) == 1);
         end
         default: begin
            rsp_stall <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_placements.size() == 0) begin
            report_error($sformatf("response with none outstanding: %p", rsp_data));
         end else begin
            want = expected_placements.pop_front();
            if (rsp_data.layer_index !== want.layer_index)
               report_error($sformatf("layer_index expected %0d got %0d",
                                      want.layer_index, rsp_data.layer_index));
            if (rsp_data.opened_new !== want.opened_new)
               report_error($sformatf("opened_new expected %0d got %0d",
                                      want.opened_new, rsp_data.opened_new));
            if (rsp_data.layers_used !== want.layers_used)
               report_error($sformatf("layers_used expected %0d got %0d",
                                      want.layers_used, rsp_data.layers_used));
            if (rsp_data.over_budget !== want.over_budget)
               report_error($sformatf("over_budget expected %0d got %0d",
                                      want.over_budget, rsp_data.over_budget));
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_table[i]) begin
         if (directed_table[i].kind == ROW_CSR)
            write_register(directed_table[i].index, directed_table[i].value);
         else
            send_request(directed_table[i].item, directed_table[i].fixed,
                         directed_table[i].result);
      end

      run_phase(4, 64, 160, 3);
      run_phase(0, 8, 160, 3);
      run_phase(1024, 64, 200, 2);
      run_phase(2047, 16, 160, 3);
      run_phase(16, 127, 160, 3);
      run_phase(1, 1, 120, 3);
      // Frequent new sets take the epoch tag past its wrap and its clearing pass.
      run_phase(2, 64, 400, 70);
      run_phase($urandom_range(1, 1024), $urandom_range(1, 64), 120, 3);
      run_phase($urandom_range(1, 64), $urandom_range(1, 64), 120, 3);

      req_valid <= 1'b0;
      while (expected_placements.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* sliding_window_layer_assigner_unit.f */
design/swla_pkg.sv
design/swla_ctrl.sv
design/swla_dp.sv
design/sliding_window_layer_assigner_unit.sv
tb/sv/tb_sliding_window_layer_assigner_unit.sv
